@@ rtl/ahbc_pkg.sv @@
// Shared types, constants and register codes for the history bar chart.
`default_nettype none
package ahbc_pkg;

  // Default geometry of the chart.
  localparam int NUM_SLOTS_DEF   = 16;
  localparam int NUM_BINS_DEF    = 3;
  localparam int SLOT_PIXELS_DEF = 8;

  // Field widths.
  localparam int LEVEL_W = 16;
  localparam int H_W     = 8;
  localparam int SCALE_W = 5;
  localparam int BIN_IDX_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd31;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MAX_HEIGHT = 2'd0,
    REG_X_ORIGIN   = 2'd1,
    REG_Y_BASELINE = 2'd2
  } reg_idx_t;

  localparam logic [H_W-1:0] MAX_HEIGHT_RST = 8'd48;
  localparam logic [H_W-1:0] X_ORIGIN_RST   = 8'd0;
  localparam logic [H_W-1:0] Y_BASELINE_RST = 8'd63;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [H_W-1:0] max_height;
    logic [H_W-1:0] x_origin;
    logic [H_W-1:0] y_baseline;
  } cfg_t;

  // Control broadcast to every history cell.
  typedef struct packed {
    logic               shift_en;
    logic               scale_en;
    logic [SCALE_W-1:0] grow;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROW,
    ST_SCALE,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/ahbc_if.sv @@
// Valid/ready channel interfaces for readings in and bars out.
`default_nettype none
interface ahbc_in_if;
  import ahbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pm1_level;
  logic [LEVEL_W-1:0] pm25_level;
  logic [LEVEL_W-1:0] pm10_level;

  modport source (output valid, pm1_level, pm25_level, pm10_level, input ready);
  modport sink   (input valid, pm1_level, pm25_level, pm10_level, output ready);
endinterface

interface ahbc_out_if #(
  parameter int SLOT_W = 4
);
  import ahbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SLOT_W-1:0]    bar_slot;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [H_W-1:0]       bar_height;
  logic [H_W-1:0]       rect_x;
  logic [H_W-1:0]       rect_y;
  logic                 last_bar;

  modport source (output valid, bar_slot, bin_index, bar_height, rect_x, rect_y, last_bar,
                  input ready);
  modport sink   (input valid, bar_slot, bin_index, bar_height, rect_x, rect_y, last_bar,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ahbc_cell.sv @@
// One history cell: holds a single bar height and passes it to its neighbor.
`default_nettype none
module ahbc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ahbc_pkg::cell_ctl_t       ctl,
  input  logic [ahbc_pkg::H_W-1:0]  data_in,
  output logic [ahbc_pkg::H_W-1:0]  data_out
);
  import ahbc_pkg::*;

  logic [H_W-1:0] h_r;
  logic [H_W-1:0] h_nxt;

  // A shift moves the neighbor's height in; a rescale divides by a power of two.
  always_comb begin
    h_nxt = h_r;
    priority if (ctl.shift_en) begin
      h_nxt = data_in;
    end else if (ctl.scale_en) begin
      h_nxt = h_r >> ctl.grow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else begin
      h_r <= h_nxt;
    end
  end

  assign data_out = h_r;

endmodule
`default_nettype wire

@@ rtl/ahbc_cfg.sv @@
// APB-style register file for bar height limit, x origin and baseline.
`default_nettype none
module ahbc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ahbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ahbc_pkg::DATA_W-1:0]  pwdata,
  output logic [ahbc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ahbc_pkg::cfg_t               cfg
);
  import ahbc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; writes past the last register are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_HEIGHT: cfg_nxt.max_height = pwdata[H_W-1:0];
        REG_X_ORIGIN:   cfg_nxt.x_origin   = pwdata[H_W-1:0];
        REG_Y_BASELINE: cfg_nxt.y_baseline = pwdata[H_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_height <= MAX_HEIGHT_RST;
      cfg_r.x_origin   <= X_ORIGIN_RST;
      cfg_r.y_baseline <= Y_BASELINE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read data.
  always_comb begin
    unique case (idx)
      REG_MAX_HEIGHT: prdata = DATA_W'(cfg_r.max_height);
      REG_X_ORIGIN:   prdata = DATA_W'(cfg_r.x_origin);
      REG_Y_BASELINE: prdata = DATA_W'(cfg_r.y_baseline);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/autoscaled_history_bar_chart.sv @@
// Top level of the autoscaled history bar chart.
// Each input beat carries up to three particulate readings. The history is a chain of
// NUM_SLOTS*NUM_BINS height cells kept oldest first, so no ring pointer is needed. An item
// goes through these steps in order: accept, grow the scale one step at a time while the
// last bin is over the limit, rescale every stored height in parallel, shift the new
// heights in at the tail one bin at a time, and rotate the chain once while the head cell
// feeds the output register; a stalled output holds the rotation. The shift scale only
// grows, and reset clears the whole history. Registers: max_bar_height at byte address 0,
// x_origin at 4, y_baseline at 8.
`default_nettype none
module autoscaled_history_bar_chart #(
  parameter int NUM_SLOTS   = ahbc_pkg::NUM_SLOTS_DEF,
  parameter int NUM_BINS    = ahbc_pkg::NUM_BINS_DEF,
  parameter int SLOT_PIXELS = ahbc_pkg::SLOT_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ahbc_in_if.sink                      in_if,
  ahbc_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ahbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ahbc_pkg::DATA_W-1:0]  pwdata,
  output logic [ahbc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ahbc_pkg::*;

  localparam int DEPTH  = NUM_SLOTS * NUM_BINS;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [BIN_W-1:0]  LAST_BIN  = BIN_W'(NUM_BINS - 1);
  localparam logic [H_W-1:0]    SLOT_STEP = H_W'(SLOT_PIXELS);

  cfg_t      cfg;
  cell_ctl_t ctl;

  logic [H_W-1:0] cell_q [DEPTH];
  logic [H_W-1:0] tail_in;
  logic [H_W-1:0] head;

  state_t state_r, state_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [SCALE_W-1:0] grow_r, grow_nxt;
  logic [LEVEL_W-1:0] rd_r [NUM_BINS];
  logic [LEVEL_W-1:0] rd_nxt [NUM_BINS];
  logic [BIN_W-1:0]   ins_r, ins_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [H_W-1:0]     xpos_r, xpos_nxt;

  logic                 ov_r, ov_nxt;
  logic [SLOT_W-1:0]    os_r, os_nxt;
  logic [BIN_IDX_W-1:0] ob_r, ob_nxt;
  logic [H_W-1:0]       oh_r, oh_nxt;
  logic [H_W-1:0]       ox_r, ox_nxt;
  logic [H_W-1:0]       oy_r, oy_nxt;
  logic                 ol_r, ol_nxt;

  logic [LEVEL_W-1:0] scaled_top;
  logic               grow_more;
  logic [LEVEL_W-1:0] ins_shifted;
  logic [H_W-1:0]     ins_val;
  logic               out_free;

  // Register file.
  ahbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Chain of history cells, oldest at index 0, fed at the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      ahbc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .data_in  (tail_in),
        .data_out (cell_q[i])
      );
    end else begin : g_body
      ahbc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .data_in  (cell_q[i+1]),
        .data_out (cell_q[i])
      );
    end
  end

  assign head = cell_q[0];

  // Scale test on the largest bin, and the saturated height of the bin being inserted.
  assign scaled_top  = rd_r[NUM_BINS-1] >> scale_r;
  assign grow_more   = (scale_r != SCALE_MAX) && (scaled_top > LEVEL_W'(cfg.max_height));
  assign ins_shifted = rd_r[ins_r] >> scale_r;
  assign ins_val     = (ins_shifted > LEVEL_W'(cfg.max_height)) ? cfg.max_height
                                                                : ins_shifted[H_W-1:0];
  assign out_free    = !ov_r || out_if.ready;

  // Sequencer: next state, cell controls and output register loads.
  always_comb begin
    state_nxt = state_r;
    scale_nxt = scale_r;
    grow_nxt  = grow_r;
    rd_nxt    = rd_r;
    ins_nxt   = ins_r;
    slot_nxt  = slot_r;
    bin_nxt   = bin_r;
    xpos_nxt  = xpos_r;
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    ob_nxt    = ob_r;
    oh_nxt    = oh_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ol_nxt    = ol_r;
    ctl.shift_en = 1'b0;
    ctl.scale_en = 1'b0;
    ctl.grow     = grow_r;
    tail_in      = head;

    if (out_if.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          for (int b = 0; b < NUM_BINS; b++) begin
            rd_nxt[b] = (b == 0) ? in_if.pm1_level :
                        (b == 1) ? in_if.pm25_level : in_if.pm10_level;
          end
          grow_nxt  = '0;
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        if (grow_more) begin
          scale_nxt = scale_r + 1'b1;
          grow_nxt  = grow_r + 1'b1;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ctl.scale_en = 1'b1;
        ins_nxt      = '0;
        state_nxt    = ST_INSERT;
      end
      ST_INSERT: begin
        ctl.shift_en = 1'b1;
        tail_in      = ins_val;
        if (ins_r == LAST_BIN) begin
          slot_nxt  = '0;
          bin_nxt   = '0;
          xpos_nxt  = cfg.x_origin;
          state_nxt = ST_EMIT;
        end else begin
          ins_nxt = ins_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.shift_en = 1'b1;
          ov_nxt = 1'b1;
          os_nxt = slot_r;
          ob_nxt = BIN_IDX_W'(bin_r);
          oh_nxt = head;
          ox_nxt = xpos_r;
          oy_nxt = (cfg.y_baseline > head) ? (cfg.y_baseline - head) : '0;
          ol_nxt = (slot_r == LAST_SLOT) && (bin_r == LAST_BIN);
          if (bin_r == LAST_BIN) begin
            bin_nxt  = '0;
            slot_nxt = slot_r + 1'b1;
            xpos_nxt = xpos_r + SLOT_STEP;
            if (slot_r == LAST_SLOT) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            bin_nxt = bin_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= '0;
      grow_r  <= '0;
      ins_r   <= '0;
      slot_r  <= '0;
      bin_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scale_r <= scale_nxt;
      grow_r  <= grow_nxt;
      ins_r   <= ins_nxt;
      slot_r  <= slot_nxt;
      bin_r   <= bin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    xpos_r <= xpos_nxt;
    os_r   <= os_nxt;
    ob_r   <= ob_nxt;
    oh_r   <= oh_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    ol_r   <= ol_nxt;
  end

  assign in_if.ready       = (state_r == ST_IDLE);
  assign out_if.valid      = ov_r;
  assign out_if.bar_slot   = os_r;
  assign out_if.bin_index  = ob_r;
  assign out_if.bar_height = oh_r;
  assign out_if.rect_x     = ox_r;
  assign out_if.rect_y     = oy_r;
  assign out_if.last_bar   = ol_r;

endmodule
`default_nettype wire
